@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL of the radix sorter.
// Depends on nothing; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

@@ design/krs_pkg.sv @@
// Shared field widths and types of the key/payload radix sorter.
// No dependencies.
package krs_pkg;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned PAY_W = 64;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [PAY_W-1:0] pay_t;
endpackage

@@ design/krs_req_if.sv @@
// Request channel of the radix sorter: one key/payload item per request.
// Depends on krs_pkg.
interface krs_req_if;
  import krs_pkg::*;
  logic valid;
  logic ready;
  key_t sort_key;
  pay_t payload_re;
  pay_t payload_im;
  logic is_last;
  modport source (output valid, sort_key, payload_re, payload_im, is_last, input ready);
  modport sink (input valid, sort_key, payload_re, payload_im, is_last, output ready);
endinterface

@@ design/krs_res_if.sv @@
// Result channel of the radix sorter: one sorted item per stored request.
// Depends on krs_pkg.
interface krs_res_if;
  import krs_pkg::*;
  logic valid;
  logic ready;
  key_t sorted_key;
  pay_t sorted_payload_re;
  pay_t sorted_payload_im;
  logic final_item;
  logic overflowed;
  modport source (output valid, sorted_key, sorted_payload_re, sorted_payload_im,
                  final_item, overflowed, input ready);
  modport sink (input valid, sorted_key, sorted_payload_re, sorted_payload_im,
                final_item, overflowed, output ready);
endinterface

@@ design/key_payload_radix_sort.sv @@
// Key/payload LSD radix sorter: top level with sequencer and memories.
// Depends on krs_pkg, krs_req_if, krs_res_if, krs_ram, assert_macros.svh.
//
// Usage: requests carry a key, a two-half payload and is_last. Up to
// MAX_ITEMS requests are stored, one per cycle; further ones are dropped
// and flag overflowed on every result of the set. A request with is_last
// (stored or dropped) starts the sort; no request is taken until the last
// result of the set has been delivered.
// Sorting runs one pass per DIGIT_BITS-bit digit of the key, ping-ponging
// between two item memories. Each pass clears the histogram, counts the
// digits, forms the prefix sums and scatters the items; the histogram
// memory has a single read and a single write port. With the defaults,
// there are four passes. Results then leave in ascending key order, stable,
// one at a time: the next is read only once the receiver has taken the
// current one, and a stalled result simply waits in the output register.
// final_item marks the last one.
// Reset empties the store and clears the overflow flag; memories are not
// cleared, as only entries written in the current set are read.
module key_payload_radix_sort #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned DIGIT_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  krs_req_if.sink   req_i,
  krs_res_if.source res_o
);
  import krs_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned SK_W     = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned ITEM_W   = SK_W + 2 * PAY_W;
  localparam int unsigned IDX_W    = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W    = $clog2(MAX_ITEMS + 1);
  localparam int unsigned HD       = 1 << DIGIT_BITS;
  localparam int unsigned HI_W     = DIGIT_BITS + 1;
  localparam int unsigned PASSES   = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned PASS_W   = $clog2(PASSES + 1);
  localparam int unsigned SH_W     = $clog2(PASSES * DIGIT_BITS + 1);

  typedef enum logic [2:0] {
    S_LOAD, S_CLR, S_CNT, S_PFX, S_SCT, S_ERD, S_ECAP, S_EWAIT
  } state_e;

  state_e               state_q;
  logic [CNT_W-1:0]     cnt_q, n_q, idx_q;
  logic                 drop_q, src_q;
  logic [HI_W-1:0]      hidx_q;
  logic [PASS_W-1:0]    pass_q;
  logic [SH_W-1:0]      shamt_q;
  logic                 s1_v_q, s2_v_q, wr_v_q, pv_q;
  logic [DIGIT_BITS-1:0] s2_d_q, wr_a_q, pa_q;
  logic [ITEM_W-1:0]    s2_item_q;
  logic [CNT_W-1:0]     wr_dat_q, acc_q;

  logic                 out_v_q, out_last_q, out_ovf_q;
  key_t                 out_key_q;
  pay_t                 out_re_q, out_im_q;

  logic [ITEM_W-1:0]    rd_a, rd_b, rd_item, wdata_item;
  logic [IDX_W-1:0]     waddr_item, raddr_item;
  logic                 we_a, we_b;
  logic [SK_W-1:0]      rd_key, key_sh;
  logic [DIGIT_BITS-1:0] rd_digit, h_raddr, h_waddr;
  logic [CNT_W-1:0]     h_rdata, h_wdata, h_cur;
  logic                 h_we;
  logic                 acc_hs, room, scat;

  assign acc_hs   = req_i.valid && req_i.ready;
  assign room     = cnt_q != CNT_W'(MAX_ITEMS);
  assign scat     = (state_q == S_SCT) && s2_v_q;
  assign rd_item  = src_q ? rd_b : rd_a;
  assign rd_key   = rd_item[ITEM_W-1 -: SK_W];
  assign key_sh   = rd_key >> shamt_q;
  assign rd_digit = key_sh[DIGIT_BITS-1:0];
  assign h_cur    = (wr_v_q && (wr_a_q == s2_d_q)) ? wr_dat_q : h_rdata;

  assign we_a       = ((state_q == S_LOAD) && acc_hs && room) || (scat && src_q);
  assign we_b       = scat && !src_q;
  assign waddr_item = (state_q == S_LOAD) ? cnt_q[IDX_W-1:0] : h_cur[IDX_W-1:0];
  assign wdata_item = (state_q == S_LOAD)
                      ? {req_i.sort_key[SK_W-1:0], req_i.payload_re, req_i.payload_im}
                      : s2_item_q;
  assign raddr_item = idx_q[IDX_W-1:0];

  always_comb begin
    h_raddr = rd_digit;
    h_we    = 1'b0;
    h_waddr = s2_d_q;
    h_wdata = h_cur + CNT_W'(1);
    case (state_q)
      S_CLR: begin
        h_we    = 1'b1;
        h_waddr = hidx_q[DIGIT_BITS-1:0];
        h_wdata = '0;
      end
      S_PFX: begin
        h_raddr = hidx_q[DIGIT_BITS-1:0];
        h_we    = pv_q;
        h_waddr = pa_q;
        h_wdata = acc_q;
      end
      S_CNT, S_SCT: begin
        h_we = s2_v_q;
      end
      default: ;
    endcase
  end

  krs_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_ITEMS), .AW(IDX_W)) u_bank_a (
    .clk_i, .we_i(we_a), .waddr_i(waddr_item), .wdata_i(wdata_item),
    .raddr_i(raddr_item), .rdata_o(rd_a)
  );
  krs_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_ITEMS), .AW(IDX_W)) u_bank_b (
    .clk_i, .we_i(we_b), .waddr_i(waddr_item), .wdata_i(wdata_item),
    .raddr_i(raddr_item), .rdata_o(rd_b)
  );
  krs_ram #(.WIDTH(CNT_W), .DEPTH(HD), .AW(DIGIT_BITS)) u_hist (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata)
  );

  assign req_i.ready             = state_q == S_LOAD;
  assign res_o.valid             = out_v_q;
  assign res_o.sorted_key        = out_key_q;
  assign res_o.sorted_payload_re = out_re_q;
  assign res_o.sorted_payload_im = out_im_q;
  assign res_o.final_item        = out_last_q;
  assign res_o.overflowed        = out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      cnt_q      <= '0;
      n_q        <= '0;
      idx_q      <= '0;
      drop_q     <= 1'b0;
      src_q      <= 1'b0;
      hidx_q     <= '0;
      pass_q     <= '0;
      shamt_q    <= '0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      wr_v_q     <= 1'b0;
      pv_q       <= 1'b0;
      s2_d_q     <= '0;
      wr_a_q     <= '0;
      pa_q       <= '0;
      s2_item_q  <= '0;
      wr_dat_q   <= '0;
      acc_q      <= '0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      out_ovf_q  <= 1'b0;
      out_key_q  <= '0;
      out_re_q   <= '0;
      out_im_q   <= '0;
    end else begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= s1_v_q;
      s2_d_q   <= rd_digit;
      s2_item_q <= rd_item;
      wr_v_q   <= s2_v_q && ((state_q == S_CNT) || (state_q == S_SCT));
      wr_a_q   <= s2_d_q;
      wr_dat_q <= h_cur + CNT_W'(1);
      case (state_q)
        S_LOAD: begin
          if (acc_hs) begin
            if (room) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end else begin
              drop_q <= 1'b1;
            end
            if (req_i.is_last) begin
              n_q     <= room ? cnt_q + CNT_W'(1) : cnt_q;
              src_q   <= 1'b0;
              pass_q  <= '0;
              shamt_q <= '0;
              hidx_q  <= '0;
              state_q <= S_CLR;
            end
          end
        end
        S_CLR: begin
          hidx_q <= hidx_q + HI_W'(1);
          if (hidx_q == HI_W'(HD - 1)) begin
            idx_q   <= '0;
            state_q <= S_CNT;
          end
        end
        S_CNT, S_SCT: begin
          if (idx_q != n_q) begin
            s1_v_q <= 1'b1;
            idx_q  <= idx_q + CNT_W'(1);
          end else if (!s1_v_q && !s2_v_q) begin
            idx_q <= '0;
            if (state_q == S_CNT) begin
              hidx_q  <= '0;
              acc_q   <= '0;
              pv_q    <= 1'b0;
              state_q <= S_PFX;
            end else begin
              src_q   <= !src_q;
              hidx_q  <= '0;
              shamt_q <= shamt_q + SH_W'(DIGIT_BITS);
              pass_q  <= pass_q + PASS_W'(1);
              state_q <= (pass_q == PASS_W'(PASSES - 1)) ? S_ERD : S_CLR;
            end
          end
        end
        S_PFX: begin
          pv_q <= 1'b0;
          pa_q <= hidx_q[DIGIT_BITS-1:0];
          if (pv_q) begin
            acc_q <= acc_q + h_rdata;
          end
          if (hidx_q != HI_W'(HD)) begin
            pv_q   <= 1'b1;
            hidx_q <= hidx_q + HI_W'(1);
          end else if (!pv_q) begin
            idx_q   <= '0;
            state_q <= S_SCT;
          end
        end
        S_ERD: begin
          state_q <= S_ECAP;
        end
        S_ECAP: begin
          out_v_q    <= 1'b1;
          out_key_q  <= KEY_W'(rd_key);
          out_re_q   <= rd_item[2*PAY_W-1:PAY_W];
          out_im_q   <= rd_item[PAY_W-1:0];
          out_last_q <= (idx_q + CNT_W'(1)) == n_q;
          out_ovf_q  <= drop_q;
          state_q    <= S_EWAIT;
        end
        S_EWAIT: begin
          if (res_o.ready) begin
            out_v_q <= 1'b0;
            if (out_last_q) begin
              cnt_q   <= '0;
              drop_q  <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              idx_q   <= idx_q + CNT_W'(1);
              state_q <= S_ERD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  `ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CNT_W'(MAX_ITEMS))
  `ASSERT_AT(a_scatter_in_range, clk_i, rst_ni, scat |-> (h_cur < n_q))
  `ASSERT_AT(a_load_idle_pipe, clk_i, rst_ni, (state_q == S_LOAD) |-> (!s1_v_q && !s2_v_q))
endmodule

@@ design/krs_ram.sv @@
// Simple dual-port synchronous RAM, one write and one read port,
// registered read data (read-before-write). No dependencies.
module krs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ test/krs_tb_if.sv @@
// Testbench package of the radix sorter: the expected-result record.
// Depends on krs_pkg.
package krs_tb_pkg;
  import krs_pkg::*;
  typedef struct packed {
    key_t key;
    pay_t re;
    pay_t im;
    logic last;
    logic ovf;
  } sorted_item_t;
endpackage

@@ test/krs_checker.sv @@
// Checker of the radix sorter: predicts each sorted burst and compares results.
// Depends on krs_pkg, krs_tb_pkg, krs_req_if and krs_res_if.
module krs_checker #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  krs_req_if.sink   req_i,
  krs_res_if.sink   res_i,
  output int        fail_count_o,
  output int        pending_o
);
  import krs_pkg::*;
  import krs_tb_pkg::*;

  sorted_item_t set_items[$];
  sorted_item_t expected_q[$];
  logic         set_dropped;
  int           fails;
  int           pend;

  assign fail_count_o = fails;
  assign pending_o    = pend;

  // stable ascending order by unsigned key; insertion sort keeps arrival order
  task automatic emit_sorted_set();
    sorted_item_t arr[$];
    sorted_item_t t;
    int j;
    arr = set_items;
    for (int i = 1; i < arr.size(); i++) begin
      t = arr[i];
      j = i - 1;
      while (j >= 0 && arr[j].key > t.key) begin
        arr[j+1] = arr[j];
        j--;
      end
      arr[j+1] = t;
    end
    foreach (arr[i]) begin
      arr[i].last = (i == arr.size() - 1);
      arr[i].ovf  = set_dropped;
      expected_q.push_back(arr[i]);
    end
    set_items.delete();
    set_dropped = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_item_t it;
    sorted_item_t got;
    if (!rst_ni) begin
      set_items.delete();
      expected_q.delete();
      set_dropped = 1'b0;
      fails = 0;
      pend = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        it = '{req_i.sort_key, req_i.payload_re, req_i.payload_im, 1'b0, 1'b0};
        if (set_items.size() < MAX_ITEMS) set_items.push_back(it);
        else set_dropped = 1'b1;
        if (req_i.is_last) emit_sorted_set();
      end
      if (res_i.valid && res_i.ready) begin
        got = '{res_i.sorted_key, res_i.sorted_payload_re, res_i.sorted_payload_im,
                res_i.final_item, res_i.overflowed};
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result %h", got);
        end else begin
          it = expected_q.pop_front();
          if (got !== it) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: key %h/%h re %h/%h im %h/%h last %b/%b ovf %b/%b",
                       it.key, got.key, it.re, got.re, it.im, got.im,
                       it.last, got.last, it.ovf, got.ovf);
          end
        end
      end
      pend = expected_q.size();
    end
  end
endmodule

@@ test/tb_key_payload_radix_sort.sv @@
// Testbench top of the radix sorter: makes requests, stalls results, gives verdict.
// Depends on krs_pkg, krs_tb_pkg, the channel interfaces, the RTL and krs_checker.
module tb_key_payload_radix_sort;
  import krs_pkg::*;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int          LIMIT     = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_off = 0;

  krs_req_if req_if();
  krs_res_if res_if();

  key_payload_radix_sort #(.MAX_ITEMS(MAX_ITEMS)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if.sink), .res_o(res_if.source));

  krs_checker #(.MAX_ITEMS(MAX_ITEMS)) u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if.sink), .res_i(res_if.sink),
    .fail_count_o(fail_count), .pending_o(pending));

  always #5 clk_i = ~clk_i;

  initial begin
    req_if.valid = 1'b0;
    req_if.sort_key = '0;
    req_if.payload_re = '0;
    req_if.payload_im = '0;
    req_if.is_last = 1'b0;
    res_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: long hold-off counted here, else random stalls
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic key_t pick_key(int mode);
    case (mode)
      0: return key_t'($urandom_range(7));
      1: return (key_t'($urandom_range(3)) << 24) | key_t'($urandom_range(3));
      default: return key_t'($urandom);
    endcase
  endfunction

  task automatic send_item(key_t k, pay_t re, pay_t im, logic last);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.sort_key <= k;
    req_if.payload_re <= re;
    req_if.payload_im <= im;
    req_if.is_last <= last;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  function automatic pay_t rnd_pay();
    return {$urandom, $urandom};
  endfunction

  task automatic send_set(int n, int mode);
    for (int i = 0; i < n; i++)
      send_item(pick_key(mode), rnd_pay(), rnd_pay(), i == n - 1);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single item, extremes, ties, reverse order
    send_item('0, '0, '0, 1'b1);
    send_item('1, '1, '1, 1'b1);
    send_item(32'hFFFF_FFFF, 64'h1, 64'h2, 1'b0);
    send_item(32'h0000_0001, 64'h3, 64'h4, 1'b0);
    send_item(32'h8000_0000, 64'h5, 64'h6, 1'b0);
    send_item(32'h0000_0001, 64'h7, 64'h8, 1'b0);
    send_item(32'h0100_0000, 64'h9, 64'hA, 1'b0);
    send_item(32'h0000_0000, 64'hB, 64'hC, 1'b1);
    for (int i = 0; i < 6; i++)
      send_item(key_t'(6 - i) << (8 * (i % 4)), rnd_pay(), rnd_pay(), i == 5);
    drain();

    // full store plus drops, last item dropped
    send_set(MAX_ITEMS + 3, 2);
    drain();

    // receiver held off; the second set waits until the first set's results are taken
    hold_off = 3000;
    send_set(16, 0);
    send_set(8, 1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      repeat (2) send_set($urandom_range(1, 5), $urandom_range(2));
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ key_payload_radix_sort.f @@
+incdir+design
design/krs_pkg.sv
design/krs_req_if.sv
design/krs_res_if.sv
design/krs_ram.sv
design/key_payload_radix_sort.sv
test/krs_tb_if.sv
test/krs_checker.sv
test/tb_key_payload_radix_sort.sv
